// ----- rtl/stt_pkg.sv -----
// Shared types, constants and character-class functions for the source text tokenizer.
// No dependencies; every RTL file of the tokenizer imports this package.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    // Widths of offsets and line numbers
    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;
    localparam int KIND_BITS   = 4;
    localparam int TDATA_BITS  = ((2 * OFFSET_BITS + LINE_BITS + 7) / 8) * 8;

    // Tokens per input byte and the group queue
    localparam int SLOTS      = 3;
    localparam int SLOT_BITS  = 2;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;

    // Keyword length minus its leading 'i'
    localparam logic [3:0] KW_TAIL_LEN = 4'd9;

    // Token kinds
    localparam logic [KIND_BITS-1:0] KIND_LPAREN     = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN     = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE     = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE     = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_LBRACKET   = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_RBRACKET   = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_END        = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER     = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_COLON      = 4'd8;
    localparam logic [KIND_BITS-1:0] KIND_SEMI       = 4'd9;
    localparam logic [KIND_BITS-1:0] KIND_STAR       = 4'd10;
    localparam logic [KIND_BITS-1:0] KIND_STRING     = 4'd11;
    localparam logic [KIND_BITS-1:0] KIND_IDENT      = 4'd12;
    localparam logic [KIND_BITS-1:0] KIND_KEYWORD    = 4'd13;
    localparam logic [KIND_BITS-1:0] KIND_UNTERM     = 4'd14;
    localparam logic [KIND_BITS-1:0] KIND_UNEXPECTED = 4'd15;

    // Characters with a special meaning
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LOWER_I = 8'h69;
    localparam logic [7:0] CH_CASE    = 8'h20;

    // Scanner modes, one-hot
    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_IDENT  = 6'b000010,
        MODE_INT    = 6'b000100,
        MODE_DOT    = 6'b001000,
        MODE_FRAC   = 6'b010000,
        MODE_STRING = 6'b100000
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] length;
    } token_t;

    // All tokens caused by one input byte
    typedef struct packed {
        logic [SLOT_BITS-1:0]      count;
        logic [LINE_BITS-1:0]      line;
        token_t [SLOTS-1:0]        tok;
    } group_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR
            || c == CH_VT || c == CH_FF;
    endfunction

    // Letters of "ntrospect", lowercase
    function automatic logic [7:0] kw_letter(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h6E;
            4'd1:    ch = 8'h74;
            4'd2:    ch = 8'h72;
            4'd3:    ch = 8'h6F;
            4'd4:    ch = 8'h73;
            4'd5:    ch = 8'h70;
            4'd6:    ch = 8'h65;
            4'd7:    ch = 8'h63;
            4'd8:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        case (c)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h5B:   k = KIND_LBRACKET;
            8'h5D:   k = KIND_RBRACKET;
            8'h3A:   k = KIND_COLON;
            8'h3B:   k = KIND_SEMI;
            8'h2A:   k = KIND_STAR;
            default: k = KIND_UNEXPECTED;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/stt_front.sv -----
// Scanner front end: scans one byte per cycle while accept is high into its token group.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_front
    import stt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] text_byte,
    output logic            push,
    output group_t          group
);

    scan_mode_t             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [3:0]             kp_reg, kp_next;
    logic                   ka_reg, ka_next;

    logic [OFFSET_BITS-1:0] off_inc, dot_off, span_off, span_dot;
    logic [OFFSET_BITS:0]   span_plus;
    logic [OFFSET_BITS-1:0] str_len;
    logic [LINE_BITS-1:0]   line_inc;
    logic                   c_letter, c_digit, c_space;
    logic                   va, vb, vc, fall;
    token_t                 tok_a, tok_b, tok_c;

    // Saturating counters and spans
    assign off_inc   = (off_reg == OFFSET_MAX) ? off_reg : off_reg + 1'b1;
    assign line_inc  = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
    assign dot_off   = (off_reg != '0) ? off_reg - 1'b1 : '0;
    assign span_off  = (off_reg >= begin_reg) ? off_reg - begin_reg : '0;
    assign span_dot  = (dot_off >= begin_reg) ? dot_off - begin_reg : '0;
    assign span_plus = {1'b0, span_off} + 1'b1;
    assign str_len   = span_plus[OFFSET_BITS] ? OFFSET_MAX : span_plus[OFFSET_BITS-1:0];

    assign c_letter = is_letter(text_byte);
    assign c_digit  = is_digit(text_byte);
    assign c_space  = is_space(text_byte);

    // Scan one byte: close the pending token, then handle the byte itself
    always_comb
    begin
        mode_next  = mode_reg;
        off_next   = off_reg;
        begin_next = begin_reg;
        line_next  = line_reg;
        kp_next    = kp_reg;
        ka_next    = ka_reg;
        va   = 1'b0;
        vb   = 1'b0;
        vc   = 1'b0;
        fall = 1'b0;
        tok_a = '{kind: KIND_NUMBER, start: begin_reg, length: span_off};
        tok_b = '{kind: KIND_UNEXPECTED, start: dot_off, length: OFFSET_BITS'(1)};
        tok_c = '{kind: KIND_END, start: off_reg, length: '0};

        if (accept)
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (c_letter || c_digit)
                    begin
                        if (ka_reg && kp_reg < KW_TAIL_LEN
                            && (text_byte | CH_CASE) == kw_letter(kp_reg))
                            kp_next = kp_reg + 1'b1;
                        else
                            ka_next = 1'b0;
                        off_next = off_inc;
                    end
                    else
                    begin
                        va = 1'b1;
                        tok_a.kind = (ka_reg && kp_reg == KW_TAIL_LEN) ? KIND_KEYWORD
                                                                        : KIND_IDENT;
                        fall = 1'b1;
                    end
                end
                MODE_INT:
                begin
                    if (c_digit)
                        off_next = off_inc;
                    else if (text_byte == CH_DOT)
                    begin
                        mode_next = MODE_DOT;
                        off_next  = off_inc;
                    end
                    else
                    begin
                        va   = 1'b1;
                        fall = 1'b1;
                    end
                end
                MODE_DOT:
                begin
                    if (c_digit)
                    begin
                        mode_next = MODE_FRAC;
                        off_next  = off_inc;
                    end
                    else
                    begin
                        va = 1'b1;
                        tok_a.length = span_dot;
                        vb   = 1'b1;
                        fall = 1'b1;
                    end
                end
                MODE_FRAC:
                begin
                    if (c_digit)
                        off_next = off_inc;
                    else
                    begin
                        va   = 1'b1;
                        fall = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (text_byte == CH_NUL)
                    begin
                        va = 1'b1;
                        tok_a.kind = KIND_UNTERM;
                        fall = 1'b1;
                    end
                    else
                    begin
                        if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE)
                        begin
                            va = 1'b1;
                            tok_a.kind   = KIND_STRING;
                            tok_a.length = str_len;
                            mode_next    = MODE_IDLE;
                        end
                        else if (text_byte == CH_NL)
                            line_next = line_inc;
                        off_next = off_inc;
                    end
                end
                default:
                begin
                    fall = 1'b1;
                end
            endcase

            if (fall)
            begin
                mode_next = MODE_IDLE;
                if (text_byte == CH_NUL)
                begin
                    // End of text: report it and start a new text
                    vc         = 1'b1;
                    off_next   = '0;
                    line_next  = LINE_BITS'(1);
                    begin_next = '0;
                    kp_next    = '0;
                    ka_next    = 1'b0;
                end
                else
                begin
                    off_next = off_inc;
                    if (c_space)
                    begin
                        if (text_byte == CH_NL)
                            line_next = line_inc;
                    end
                    else if (c_letter)
                    begin
                        begin_next = off_reg;
                        mode_next  = MODE_IDENT;
                        kp_next    = '0;
                        ka_next    = (text_byte == CH_LOWER_I);
                    end
                    else if (c_digit)
                    begin
                        begin_next = off_reg;
                        mode_next  = MODE_INT;
                    end
                    else if (text_byte == CH_DQUOTE)
                    begin
                        begin_next = off_reg;
                        mode_next  = MODE_STRING;
                    end
                    else
                    begin
                        vc = 1'b1;
                        tok_c.kind   = punct_kind(text_byte);
                        tok_c.length = OFFSET_BITS'(1);
                    end
                end
            end
        end
    end

    // Pack the tokens into the lowest slots, in order
    always_comb
    begin
        group.count  = SLOT_BITS'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
        group.line   = line_reg;
        group.tok[0] = va ? tok_a : tok_c;
        group.tok[1] = vb ? tok_b : tok_c;
        group.tok[2] = tok_c;
    end

    assign push = va || vb || vc;

    // Hold scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            off_reg   <= '0;
            begin_reg <= '0;
            line_reg  <= LINE_BITS'(1);
            kp_reg    <= '0;
            ka_reg    <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            off_reg   <= off_next;
            begin_reg <= begin_next;
            line_reg  <= line_next;
            kp_reg    <= kp_next;
            ka_reg    <= ka_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/stt_queue.sv -----
// Short queue of token groups between the scanner front end and the output serializer.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_queue
    import stt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  group_t    wr_data,
    output logic      full,
    input  wire logic rd_en,
    output logic      rd_valid,
    output group_t    rd_data
);

    group_t                slot_mem [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;

    assign full     = (count_reg == QCNT_BITS'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_mem[rd_ptr_reg];

    // Store a group
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("group written into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_valid)
        else $error("group popped from an empty queue");

    a_nonempty_group: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_data.count != '0)
        else $error("group with no tokens written");

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid |-> rd_data.count != '0)
        else $error("queue head holds a group with no tokens");
`endif

endmodule

`default_nettype wire

// ----- rtl/stt_back.sv -----
// Output serializer: sends queued tokens via a register, one per cycle while tready is high.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_back
    import stt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   rd_valid,
    input  group_t                      rd_data,
    output logic                        rd_en,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TDATA_BITS-1:0]       m_axis_tdata,  // token_start, token_length, token_line
    output logic [KIND_BITS-1:0]        m_axis_tuser,  // token_kind
    output logic                        m_axis_tlast
);

    logic [SLOT_BITS-1:0]  idx_reg;
    logic                  out_valid_reg;
    token_t                out_tok_reg;
    logic [LINE_BITS-1:0]  out_line_reg;
    logic                  out_last_reg;

    logic                  load, is_last;
    token_t                sel_tok;

    assign load    = rd_valid && (!out_valid_reg || m_axis_tready);
    assign is_last = (idx_reg + 1'b1 == rd_data.count);
    assign rd_en   = load && is_last;

    // Pick the current slot of the head group
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_tok = rd_data.tok[0];
            2'd1:    sel_tok = rd_data.tok[1];
            2'd2:    sel_tok = rd_data.tok[2];
            default: sel_tok = rd_data.tok[0];
        endcase
    end

    // Advance slot index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= is_last ? '0 : idx_reg + 1'b1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the token until the receiver takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_tok_reg  <= sel_tok;
            out_line_reg <= rd_data.line;
            out_last_reg <= is_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_tok_reg.kind;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(TDATA_BITS - 2 * OFFSET_BITS - LINE_BITS){1'b0}},
                            out_line_reg, out_tok_reg.length, out_tok_reg.start};

endmodule

`default_nettype wire

// ----- rtl/source_text_tokenizer_core.sv -----
// Source text tokenizer: top level joining scanner front end, group queue and serializer.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
//
// Usage:
//   s_axis carries one source byte per request in tdata; byte 0 ends the text.
//   m_axis carries one token per request: tuser is the kind, tdata packs start
//   offset, length and line number, tlast marks the final token caused by a byte.
//   A byte is taken every cycle while the four-entry group queue has room. The
//   scanner state advances in the accepting cycle; a byte causes zero to three
//   tokens. Its group enters the queue at the accepting edge; the output
//   register then loads its tokens from the queue head, one token per
//   cycle while m_axis_tready is high.
//   Sustained rate is one byte per cycle while bytes average one token or less;
//   the output serializer sets the limit otherwise.
//   When the receiver stalls, the output register holds its token, the queue
//   fills and s_axis_tready drops once all four entries are used.
//   Reset clears the scanner to idle between tokens at offset 0, line 1, and
//   empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer_core
    import stt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // text_byte
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TDATA_BITS-1:0]       m_axis_tdata,   // token_start, token_length, token_line
    output logic [KIND_BITS-1:0]        m_axis_tuser,   // token_kind
    output logic                        m_axis_tlast    // last_of_run
);

    logic   q_full, q_rd_valid, q_rd_en, push, accept;
    group_t front_group, q_rd_data;

    // Take a byte whenever the queue can hold its group
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    stt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (s_axis_tdata),
        .push      (push),
        .group     (front_group)
    );

    stt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (front_group),
        .full     (q_full),
        .rd_en    (q_rd_en),
        .rd_valid (q_rd_valid),
        .rd_data  (q_rd_data)
    );

    stt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_valid      (q_rd_valid),
        .rd_data       (q_rd_data),
        .rd_en         (q_rd_en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
